// ===== rtl/sapq_pkg.sv =====
package sapq_pkg;

  localparam int VALUE_W = 32;
  localparam int COUNT_W = 5;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_DELETE = 1'b1
  } cmd_t;

  typedef logic signed [VALUE_W-1:0] value_t;

  // Broadcast to every cell for one transfer.
  typedef struct packed {
    logic   ins;
    logic   del;
    value_t value;
  } cell_ctrl_t;

endpackage

// ===== rtl/sorted_array_priority_queue.sv =====
// Each command passes through the cell row in the cycle of its transfer;
// its result appears on the output register in the cycle after the
// command transfer. Throughput is one command per cycle while no result
// is held by res_stall, limited by the single compare and shift step that
// every cell performs in the cycle of the transfer. Reset empties the queue
// (all cell valid bits cleared, count zero) and drops any pending result.
module sorted_array_priority_queue #(
  parameter int DEPTH = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cmd_valid,
  output logic                  cmd_stall,
  input  logic                  cmd,
  input  logic signed [31:0]    value,
  output logic                  res_valid,
  input  logic                  res_stall,
  output logic [1:0]            status,
  output logic [4:0]            count,
  output logic signed [31:0]    head_value
);
  import sapq_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  logic [DEPTH-1:0] vld;
  value_t           data [DEPTH];
  logic [DEPTH-1:0] ge;
  logic [DEPTH-1:0] eq;

  cell_ctrl_t ctrl;
  logic       take;
  logic       full;
  logic       empty;
  logic       found;

  logic [CW-1:0] cnt;
  logic [CW-1:0] cnt_next;
  status_t       st;
  status_t       st_next;
  logic          res_valid_next;

  assign cmd_stall = res_valid && res_stall;
  assign take      = cmd_valid && !cmd_stall;
  assign full      = vld[DEPTH-1];
  assign empty     = !vld[0];
  assign found     = |eq;

  always_comb begin
    ctrl.value = value;
    ctrl.ins   = take && (cmd == CMD_INSERT) && !full;
    ctrl.del   = take && (cmd == CMD_DELETE) && found;
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic   l_ge;
    logic   l_vld;
    value_t l_data;
    logic   r_vld;
    value_t r_data;

    if (i == 0) begin : g_first
      assign l_ge   = 1'b0;
      assign l_vld  = 1'b0;
      assign l_data = '0;
    end else begin : g_mid_l
      assign l_ge   = ge[i-1];
      assign l_vld  = vld[i-1];
      assign l_data = data[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign r_vld  = 1'b0;
      assign r_data = '0;
    end else begin : g_mid_r
      assign r_vld  = vld[i+1];
      assign r_data = data[i+1];
    end

    sapq_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .left_ge    (l_ge),
      .left_vld   (l_vld),
      .left_data  (l_data),
      .right_vld  (r_vld),
      .right_data (r_data),
      .vld        (vld[i]),
      .data       (data[i]),
      .ge         (ge[i]),
      .eq         (eq[i])
    );
  end

  always_comb begin
    cnt_next       = cnt;
    st_next        = st;
    res_valid_next = res_valid && res_stall;
    if (take) begin
      res_valid_next = 1'b1;
      if (cmd == CMD_INSERT) begin
        if (full) begin
          st_next = ST_OVERFLOW;
        end else begin
          st_next  = ST_DONE;
          cnt_next = cnt + CW'(1);
        end
      end else begin
        if (empty) begin
          st_next = ST_EMPTY;
        end else if (found) begin
          st_next  = ST_DONE;
          cnt_next = cnt - CW'(1);
        end else begin
          st_next = ST_NOT_FOUND;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      st        <= ST_DONE;
      res_valid <= 1'b0;
    end else begin
      cnt       <= cnt_next;
      st        <= st_next;
      res_valid <= res_valid_next;
    end
  end

  // The cells only change on a transfer, which cannot happen while a
  // result is held, so the head is read straight from the first cell.
  assign status     = st;
  assign count      = COUNT_W'(cnt);
  assign head_value = vld[0] ? data[0] : '0;

endmodule

// ===== rtl/sapq_cell.sv =====
module sapq_cell (
  input  logic                clk,
  input  logic                rst,
  input  sapq_pkg::cell_ctrl_t ctrl,
  input  logic                left_ge,
  input  logic                left_vld,
  input  sapq_pkg::value_t    left_data,
  input  logic                right_vld,
  input  sapq_pkg::value_t    right_data,
  output logic                vld,
  output sapq_pkg::value_t    data,
  output logic                ge,
  output logic                eq
);
  import sapq_pkg::*;

  logic   vld_next;
  value_t data_next;
  logic   le;

  // The row is sorted in descending order with the valid entries first, so
  // ge is false up to the insert position and true from there on.
  assign ge = !vld || (ctrl.value >= data);
  assign le = vld && (data <= ctrl.value);
  assign eq = vld && (data == ctrl.value);

  always_comb begin
    vld_next  = vld;
    data_next = data;
    if (ctrl.ins) begin
      if (left_ge) begin
        vld_next  = left_vld;
        data_next = left_data;
      end else if (ge) begin
        vld_next  = 1'b1;
        data_next = ctrl.value;
      end
    end else if (ctrl.del) begin
      // Equal values sit together, so every valid cell at or past the first match
      // pulls in its right neighbor.
      if (le) begin
        vld_next  = right_vld;
        data_next = right_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else begin
      vld <= vld_next;
    end
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule
